### rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qafe_pkg.sv
`default_nettype none

package qafe_pkg;

  localparam int unsigned FracBits = 32;
  localparam int unsigned IterW    = 16;
  localparam int unsigned ValW     = 48;
  localparam int unsigned HalfW    = ValW / 2;
  localparam int unsigned ProdW    = 2 * ValW;
  localparam int unsigned MagW     = 63;
  localparam int unsigned MinW     = FracBits + 3;
  localparam int unsigned TermW    = 62;
  localparam int unsigned SumW     = 64;
  localparam int unsigned OutIterW = 16;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [CfgAddrW-1:0] CfgFormula = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgJulia   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgLimit   = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgSeedRe  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgSeedIm  = 3'd4;

  typedef enum logic [1:0] {
    MulRr = 2'd0,
    MulIi = 2'd1,
    MulRi = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     term;
    logic     comb;
    logic     upd;
    logic     mag;
    logic     check;
    logic     itr_inc;
    logic     publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lim_zero;
    logic mul_done;
    logic last_iter;
    logic zs_lt_low;
    logic zs_gt_brk;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/qafe_in_if.sv
`default_nettype none

interface qafe_in_if import qafe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] point_re;
  logic signed [ValW-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink (input valid, input point_re, input point_im, output ready);
endinterface

`default_nettype wire

### rtl/qafe_out_if.sv
`default_nettype none

interface qafe_out_if import qafe_pkg::*; ();
  logic                escaped;
  logic                valid;
  logic                ready;
  logic [OutIterW-1:0] escape_iteration;
  logic [MagW-1:0]     final_magnitude_sq;
  logic [MinW-1:0]     min_magnitude_sq;

  modport source (output valid, output escaped, output escape_iteration,
                  output final_magnitude_sq, output min_magnitude_sq, input ready);
  modport sink (input valid, input escaped, input escape_iteration,
                input final_magnitude_sq, input min_magnitude_sq, output ready);
endinterface

`default_nettype wire

### rtl/qafe_cfg_if.sv
`default_nettype none

interface qafe_cfg_if import qafe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [ValW-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### rtl/quadratic_abs_fractal_escape_top.sv
// When the limit is zero an accepted word goes straight to the output; one word is in work
// at a time. Each iteration makes three passes through the one shared multiplier (four
// 24x24 partial products each) plus the update and test states Term, Comb, Upd, Mag
// and Chk.
// A finished word waits in the output register while the next word is taken.
// Reset (rst_ni low, asynchronous) clears control state and loads the register defaults.
`default_nettype none

`include "assert_macros.svh"

module quadratic_abs_fractal_escape_top import qafe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qafe_in_if.sink   in_i,
  qafe_out_if.source out_o,
  qafe_cfg_if.sink  cfg_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  qafe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qafe_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_i),
    .point_re_i           (in_i.point_re),
    .point_im_i           (in_i.point_im),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .escaped_o            (out_o.escaped),
    .escape_iteration_o   (out_o.escape_iteration),
    .final_magnitude_sq_o (out_o.final_magnitude_sq),
    .min_magnitude_sq_o   (out_o.min_magnitude_sq)
  );

  `ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "second word taken while busy")
  `ASSERT_NEXT(a_publish, clk_i, rst_ni, cmd.publish, out_o.valid, "published word not presented")
  `ASSERT_NEXT(a_single_start, clk_i, rst_ni, cmd.mul_start, !cmd.mul_start, "multiplier restarted")
  `ASSERT_IMPLIES(a_start_idle, clk_i, rst_ni, sts.mul_done, !cmd.mul_start, "start while product completes")

endmodule

`default_nettype wire

### rtl/qafe_mul.sv
`default_nettype none

// Unsigned 48x48 multiplier built from four 24x24 partial products, one per
// cycle, followed by the fixed-point shift with saturation to 63 bits.
module qafe_mul import qafe_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ValW-1:0] a_i,
  input  wire logic [ValW-1:0] b_i,
  output logic                 done_o,
  output logic [MagW-1:0]      q_o,
  output logic                 rnz_o
);

  localparam logic [2:0] NumParts = 3'd4;
  localparam logic [2:0] LastStep = 3'd5;

  logic            busy_q, done_q, pv_q;
  logic [2:0]      cnt_q;
  logic [1:0]      pk_q;
  logic [ValW-1:0] a_q, b_q, pp_q;
  logic [ProdW-1:0] acc_q;
  logic [MagW-1:0] q_q;
  logic            rnz_q;

  logic [HalfW-1:0] a_part, b_part;
  logic [ProdW-1:0] pp_shift, shr;

  // Part order: lo*lo, lo*hi, hi*lo, hi*hi.
  assign a_part = cnt_q[1] ? a_q[ValW-1:HalfW] : a_q[HalfW-1:0];
  assign b_part = cnt_q[0] ? b_q[ValW-1:HalfW] : b_q[HalfW-1:0];

  always_comb begin
    case (pk_q)
      2'd0:    pp_shift = ProdW'(pp_q);
      2'd1:    pp_shift = ProdW'(pp_q) << HalfW;
      2'd2:    pp_shift = ProdW'(pp_q) << HalfW;
      default: pp_shift = ProdW'(pp_q) << (2 * HalfW);
    endcase
  end

  assign shr = acc_q >> FracBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        pv_q   <= 1'b0;
      end else if (busy_q) begin
        pv_q  <= (cnt_q < NumParts);
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end else begin
        pv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (busy_q && (cnt_q < NumParts)) begin
        pp_q <= ValW'(a_part * b_part);
        pk_q <= cnt_q[1:0];
      end
      if (pv_q) begin
        acc_q <= acc_q + pp_shift;
      end
      if (busy_q && (cnt_q == LastStep)) begin
        q_q   <= (|shr[ProdW-1:MagW]) ? '1 : shr[MagW-1:0];
        rnz_q <= |acc_q[FracBits-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign rnz_o  = rnz_q;

endmodule

`default_nettype wire

### rtl/qafe_ctrl.sv
`default_nettype none

module qafe_ctrl import qafe_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  input  wire dp_sts_t sts_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StRr   = 10'b00_0000_0010,
    StIi   = 10'b00_0000_0100,
    StRi   = 10'b00_0000_1000,
    StTerm = 10'b00_0001_0000,
    StComb = 10'b00_0010_0000,
    StUpd  = 10'b00_0100_0000,
    StMag  = 10'b00_1000_0000,
    StChk  = 10'b01_0000_0000,
    StDone = 10'b10_0000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        iss_q, iss_d;
  logic        first_q, first_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    iss_d         = iss_q;
    first_d       = first_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MulRr;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          first_d    = 1'b1;
          state_d    = sts_i.lim_zero ? StDone : StRr;
        end
      end
      StRr: begin
        cmd_o.mul_sel   = MulRr;
        cmd_o.mul_start = !iss_q;
        iss_d           = 1'b1;
        if (sts_i.mul_done) begin
          iss_d   = 1'b0;
          state_d = StIi;
        end
      end
      StIi: begin
        cmd_o.mul_sel   = MulIi;
        cmd_o.mul_start = !iss_q;
        iss_d           = 1'b1;
        if (sts_i.mul_done) begin
          iss_d   = 1'b0;
          state_d = first_q ? StRi : StMag;
        end
      end
      StRi: begin
        cmd_o.mul_sel   = MulRi;
        cmd_o.mul_start = !iss_q;
        iss_d           = 1'b1;
        if (sts_i.mul_done) begin
          iss_d   = 1'b0;
          state_d = StTerm;
        end
      end
      StTerm: begin
        cmd_o.term = 1'b1;
        state_d    = StComb;
      end
      StComb: begin
        cmd_o.comb = 1'b1;
        state_d    = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        first_d   = 1'b0;
        state_d   = StRr;
      end
      StMag: begin
        cmd_o.mag = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        cmd_o.check = 1'b1;
        // A new minimum never counts as an escape in the same iteration.
        if (!sts_i.zs_lt_low && sts_i.zs_gt_brk) begin
          state_d = StDone;
        end else if (sts_i.last_iter) begin
          state_d = StDone;
        end else begin
          cmd_o.itr_inc = 1'b1;
          state_d       = StRi;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iss_q       <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/qafe_dp.sv
`default_nettype none

module qafe_dp import qafe_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  qafe_cfg_if.sink                    cfg_i,
  input  wire logic signed [ValW-1:0] point_re_i,
  input  wire logic signed [ValW-1:0] point_im_i,
  input  wire ctrl_cmd_t              cmd_i,
  output dp_sts_t                     sts_o,
  output logic                        escaped_o,
  output logic [OutIterW-1:0]         escape_iteration_o,
  output logic [MagW-1:0]             final_magnitude_sq_o,
  output logic [MinW-1:0]             min_magnitude_sq_o
);

  localparam int unsigned FbNegRe  = 0;
  localparam int unsigned FbAddIm  = 1;
  localparam int unsigned FbNegDbl = 2;
  localparam int unsigned FbAbsR1  = 3;
  localparam int unsigned FbAbsI1  = 4;
  localparam int unsigned FbAbsR2  = 5;
  localparam int unsigned FbAbsI2  = 6;
  localparam int unsigned FbAbsRe  = 7;

  localparam logic [MagW-1:0] ProdLim = MagW'(1) << 60;
  localparam logic [MagW-1:0] Brk     = MagW'(4096) << FracBits;
  localparam logic [MinW-1:0] LowInit = MinW'(4) << FracBits;
  localparam logic signed [SumW-1:0] ValMax =
    {{(SumW - ValW + 1){1'b0}}, {(ValW - 1){1'b1}}};
  localparam logic signed [SumW-1:0] ValMin = ~ValMax;

  typedef struct packed {
    logic [MagW-1:0] q;
    logic            rnz;
  } prod_t;

  // Configuration registers.
  logic [7:0]             formula_q;
  logic [1:0]             julia_q;
  logic [IterW-1:0]       limit_q;
  logic signed [ValW-1:0] seed_re_q, seed_im_q;

  // Iteration state.
  logic signed [ValW-1:0]  zr_q, zi_q, cr_q, ci_q;
  prod_t                   rr_q, ii_q, ri_q;
  logic signed [TermW-1:0] t1_q, t2_q, t3_q;
  logic signed [SumW-1:0]  re_q, im_q;
  logic [MagW-1:0]         zs_q;
  logic [MinW-1:0]         low_q;
  logic [IterW-1:0]        itr_q;
  logic                    esc_q;

  logic                res_esc_q;
  logic [OutIterW-1:0] res_iter_q;
  logic [MagW-1:0]     res_final_q;
  logic [MinW-1:0]     res_min_q;

  logic [ValW-1:0]  mul_a, mul_b;
  logic             mul_done;
  logic [MagW-1:0]  mul_q;
  logic             mul_rnz;
  logic             zr_neg, zi_neg;
  logic signed [TermW-1:0] t1_d, t2_d, t3_d;
  logic signed [SumW-1:0]  t1_x, t2_x, t3_x, re_sum, re_abs, re_d, im_dbl, im_d;
  logic [MagW:0]    zs_sum;

  function automatic logic [ValW-1:0] mag_of(logic signed [ValW-1:0] v);
    return v[ValW-1] ? ValW'(-v) : ValW'(v);
  endfunction

  // Product shifted down, rounded toward minus infinity when negative,
  // clamped to 2^60 and given its sign.
  function automatic logic signed [TermW-1:0] term_of(prod_t p, logic neg);
    logic [MagW-1:0]  m;
    logic [TermW-1:0] u;
    m = (p.q >= ProdLim) ? ProdLim : p.q + MagW'(neg & p.rnz);
    u = {1'b0, m[TermW-2:0]};
    return neg ? -$signed(u) : $signed(u);
  endfunction

  function automatic logic signed [ValW-1:0] sat_val(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] s;
    s = v;
    if (v > ValMax) begin
      s = ValMax;
    end else if (v < ValMin) begin
      s = ValMin;
    end
    return $signed(s[ValW-1:0]);
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      formula_q <= '0;
      julia_q   <= '0;
      limit_q   <= IterW'(256);
      seed_re_q <= '0;
      seed_im_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CfgFormula: formula_q <= cfg_i.data[7:0];
        CfgJulia:   julia_q   <= cfg_i.data[1:0];
        CfgLimit:   limit_q   <= IterW'(cfg_i.data[15:0]);
        CfgSeedRe:  seed_re_q <= $signed(cfg_i.data);
        CfgSeedIm:  seed_im_q <= $signed(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

  assign zr_neg = zr_q[ValW-1];
  assign zi_neg = zi_q[ValW-1];

  always_comb begin
    case (cmd_i.mul_sel)
      MulIi: begin
        mul_a = mag_of(zi_q);
        mul_b = mag_of(zi_q);
      end
      MulRi: begin
        mul_a = mag_of(zr_q);
        mul_b = mag_of(zi_q);
      end
      default: begin
        mul_a = mag_of(zr_q);
        mul_b = mag_of(zr_q);
      end
    endcase
  end

  qafe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .q_o     (mul_q),
    .rnz_o   (mul_rnz)
  );

  // An absolute value on an operand only moves the sign of the product.
  assign t1_d = term_of(rr_q, zr_neg & formula_q[FbAbsR1]);
  assign t2_d = term_of(ii_q, zi_neg & formula_q[FbAbsI1]);
  assign t3_d = term_of(ri_q, (zr_neg & ~formula_q[FbAbsR2]) ^
                              (zi_neg & ~formula_q[FbAbsI2]));

  assign t1_x   = SumW'(t1_q);
  assign t2_x   = SumW'(t2_q);
  assign t3_x   = SumW'(t3_q);
  assign re_sum = formula_q[FbAddIm] ? (t1_x + t2_x) : (t1_x - t2_x);
  assign re_abs = (formula_q[FbAbsRe] && re_sum[SumW-1]) ? -re_sum : re_sum;
  assign re_d   = formula_q[FbNegRe] ? -re_abs : re_abs;
  assign im_dbl = t3_x <<< 1;
  assign im_d   = formula_q[FbNegDbl] ? -im_dbl : im_dbl;

  // Two squares below 2^63 overflow 63 bits exactly when the carry is set.
  assign zs_sum = {1'b0, rr_q.q} + {1'b0, ii_q.q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (julia_q[0]) begin
        zr_q <= point_re_i;
        zi_q <= point_im_i;
        cr_q <= seed_re_q;
        ci_q <= seed_im_q;
      end else begin
        cr_q <= point_re_i;
        ci_q <= point_im_i;
        zr_q <= julia_q[1] ? '0 : seed_re_q;
        zi_q <= julia_q[1] ? '0 : seed_im_q;
      end
      itr_q <= '0;
      zs_q  <= '0;
      low_q <= LowInit;
      esc_q <= 1'b0;
    end
    if (mul_done) begin
      case (cmd_i.mul_sel)
        MulIi:   ii_q <= '{q: mul_q, rnz: mul_rnz};
        MulRi:   ri_q <= '{q: mul_q, rnz: mul_rnz};
        default: rr_q <= '{q: mul_q, rnz: mul_rnz};
      endcase
    end
    if (cmd_i.term) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
      t3_q <= t3_d;
    end
    if (cmd_i.comb) begin
      re_q <= re_d;
      im_q <= im_d;
    end
    if (cmd_i.upd) begin
      zr_q <= sat_val(re_q + SumW'(cr_q));
      zi_q <= sat_val(im_q + SumW'(ci_q));
    end
    if (cmd_i.mag) begin
      zs_q <= zs_sum[MagW] ? '1 : zs_sum[MagW-1:0];
    end
    if (cmd_i.check) begin
      if (sts_o.zs_lt_low) begin
        low_q <= zs_q[MinW-1:0];
      end else if (sts_o.zs_gt_brk) begin
        esc_q <= 1'b1;
      end
    end
    if (cmd_i.itr_inc) begin
      itr_q <= itr_q + IterW'(1);
    end
    if (cmd_i.publish) begin
      res_esc_q   <= esc_q;
      res_iter_q  <= OutIterW'(esc_q ? itr_q : limit_q);
      res_final_q <= zs_q;
      res_min_q   <= low_q;
    end
  end

  assign sts_o.lim_zero  = (limit_q == '0);
  assign sts_o.mul_done  = mul_done;
  assign sts_o.last_iter = (({1'b0, itr_q} + (IterW + 1)'(1)) == {1'b0, limit_q});
  assign sts_o.zs_lt_low = (zs_q < MagW'(low_q));
  assign sts_o.zs_gt_brk = (zs_q > Brk);

  assign escaped_o            = res_esc_q;
  assign escape_iteration_o   = res_iter_q;
  assign final_magnitude_sq_o = res_final_q;
  assign min_magnitude_sq_o   = res_min_q;

endmodule

`default_nettype wire
